// ===== src/stpm_pkg.sv =====
// Shared package for the shared timer period meter: operation codes,
// register indexes, reset values and the divider status type.
// Depends on nothing; used by every file under src.
package stpm_pkg;

   // width of the period, frequency and oscillator words
   localparam int unsigned DATA_W = 32;

   // operation codes carried by req_func
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_EDGE   = 2'd1;
   localparam logic [1:0] FUNC_SECOND = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   // register indexes on the csr port
   localparam logic CSR_OSC_FREQ = 1'b0;
   localparam logic CSR_TIMEOUT  = 1'b1;

   // reset values and fixed words
   localparam logic [DATA_W-1:0] OSC_FREQ_RESET = 32'd11059200;
   localparam logic [DATA_W-1:0] TIMEOUT_RESET  = 32'hC0_0000;
   localparam logic [DATA_W-1:0] ALL_ONES       = 32'hFFFF_FFFF;

   // divider status seen by the top level
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== src/shared_timer_period_meter_unit.sv =====
// Top level of the shared timer period meter: timer ownership, periods,
// edge tallies, configuration registers and the result register.
// Depends on stpm_pkg and stpm_div.
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+-------------------------------
//   req       | in        | req_valid/req_ready | req_func, req_channel
//   rsp       | out       | rsp_valid/rsp_ready | rsp_freq_value, rsp_freq_channel
//   csr       | in        | csr_write_en        | csr_index, csr_wdata
//
// Ticks, edges and one-second ticks are taken back to back while the divider is idle.
// A read goes through the bit-serial divider, which gives one quotient
// bit a cycle, and the input stays stalled until the result register takes it.
// Reset is synchronous and clears periods, tallies, owner and count at once.
// A stalled result holds in the output register; non-reads flow unless a division waits.
module shared_timer_period_meter_unit #(
   parameter int unsigned NUM_CHANNELS = 2,
   parameter int unsigned TALLY_WIDTH  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_func,
   input  logic                         req_channel,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [stpm_pkg::DATA_W-1:0] rsp_freq_value,
   output logic                         rsp_freq_channel,
   input  logic                         csr_write_en,
   input  logic                         csr_index,
   input  logic [stpm_pkg::DATA_W-1:0] csr_wdata
);
   import stpm_pkg::*;

   localparam int unsigned OWN_W = $clog2(NUM_CHANNELS + 1);

   logic [DATA_W-1:0]      osc_ff, timeout_ff;
   logic [OWN_W-1:0]       owner_ff, owner_in;
   logic [DATA_W-1:0]      elapsed_ff, elapsed_in;
   logic [DATA_W-1:0]      period_ff [NUM_CHANNELS];
   logic [DATA_W-1:0]      period_in [NUM_CHANNELS];
   logic [TALLY_WIDTH-1:0] tally_ff [NUM_CHANNELS];
   logic [TALLY_WIDTH-1:0] tally_in [NUM_CHANNELS];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_value_ff;
   logic                   rsp_chan_ff;
   logic                   rd_chan_ff;

   logic                   accept;
   logic                   ch_ok;
   logic [DATA_W-1:0]      elapsed_inc;
   logic [DATA_W-1:0]      rd_period;
   logic                   div_start;
   logic                   div_take;
   logic [DATA_W-1:0]      div_quo;
   div_status_type         div_stat;

   assign req_ready = !div_stat.busy;
   assign accept    = req_valid && req_ready;
   assign ch_ok     = (32'(req_channel) < NUM_CHANNELS);

   // saturating count step
   assign elapsed_inc = (elapsed_ff == ALL_ONES) ? elapsed_ff : elapsed_ff + 1'b1;

   // period selected for a read; an invalid channel divides by zero
   always_comb begin
      rd_period = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (32'(req_channel) == 32'(i)) begin
            rd_period = period_ff[i];
         end
      end
   end

   // timer ownership, periods and tallies
   always_comb begin
      owner_in   = owner_ff;
      elapsed_in = elapsed_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         period_in[i] = period_ff[i];
         tally_in[i]  = tally_ff[i];
      end
      if (accept) begin
         case (req_func)
            FUNC_TICK: begin
               if (owner_ff != '0) begin
                  if (elapsed_inc > timeout_ff) begin
                     for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (owner_ff == OWN_W'(i + 1)) begin
                           period_in[i] = ALL_ONES;
                        end
                     end
                     owner_in   = '0;
                     elapsed_in = '0;
                  end else begin
                     elapsed_in = elapsed_inc;
                  end
               end
            end
            FUNC_EDGE: begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (ch_ok && 32'(req_channel) == 32'(i)) begin
                     if (tally_ff[i] != '1) begin
                        tally_in[i] = tally_ff[i] + 1'b1;
                     end
                     if (owner_ff == OWN_W'(i + 1)) begin
                        period_in[i] = elapsed_ff;
                        owner_in     = '0;
                     end else if (owner_ff == '0) begin
                        elapsed_in = '0;
                        owner_in   = OWN_W'(i + 1);
                     end
                  end
               end
            end
            FUNC_SECOND: begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (tally_ff[i] == '0) begin
                     period_in[i] = ALL_ONES;
                  end
                  tally_in[i] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff   <= '0;
         elapsed_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            period_ff[i] <= '0;
            tally_ff[i]  <= '0;
         end
      end else begin
         owner_ff   <= owner_in;
         elapsed_ff <= elapsed_in;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            period_ff[i] <= period_in[i];
            tally_ff[i]  <= tally_in[i];
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         osc_ff     <= OSC_FREQ_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_OSC_FREQ: osc_ff     <= csr_wdata;
            CSR_TIMEOUT:  timeout_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // read path through the divider
   assign div_start = accept && (req_func == FUNC_READ);
   assign div_take  = div_stat.done && (!rsp_valid_ff || rsp_ready);

   stpm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (osc_ff),
      .divisor  (ch_ok ? rd_period : '0),
      .take     (div_take),
      .quotient (div_quo),
      .status   (div_stat)
   );

   always_ff @(posedge clock) begin
      if (div_start) begin
         rd_chan_ff <= req_channel;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (div_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_take) begin
         rsp_value_ff <= div_quo;
         rsp_chan_ff  <= rd_chan_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_freq_value   = rsp_value_ff;
   assign rsp_freq_channel = rsp_chan_ff;

endmodule

// ===== src/stpm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on stpm_pkg. A zero divisor gives an all-ones quotient.
module stpm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [stpm_pkg::DATA_W-1:0] dividend,
   input  logic [stpm_pkg::DATA_W-1:0] divisor,
   input  logic                         take,
   output logic [stpm_pkg::DATA_W-1:0] quotient,
   output stpm_pkg::div_status_type     status
);
   import stpm_pkg::*;

   localparam int unsigned CNT_W = $clog2(DATA_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   // one restoring step: shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               cnt_in   = CNT_W'(DATA_W - 1);
               rem_in   = '0;
               quo_in   = dividend;
               dvs_in   = divisor;
            end
         end
         ST_RUN: begin
            if (!diff[DATA_W]) begin
               rem_in = diff[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

endmodule

// ===== src/stpm_checker.sv =====
// Port-level checks for the shared timer period meter, and the bind
// that attaches them to the top level. Depends on stpm_pkg.
module stpm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [1:0]                   req_func,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [stpm_pkg::DATA_W-1:0] rsp_freq_value
);
   import stpm_pkg::*;

   // a stalled result stays offered with the same value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_freq_value))
      else $error("stalled result dropped or changed");

   // an accepted read stalls the input while the divider runs
   a_read_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_READ |=> !req_ready)
      else $error("input not stalled after read");

   // other items never stall the input
   a_other_flows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != FUNC_READ |=> req_ready)
      else $error("input stalled after non-read item");

   // a new result appears only at the end of a division
   a_rsp_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without division");

endmodule

bind shared_timer_period_meter_unit stpm_checker u_stpm_checker (.*);

// ===== dv/shared_timer_period_meter_unit_tb.sv =====
// Self-checking testbench for shared_timer_period_meter_unit: directed and random
// ticks, edges, one-second ticks and reads, checked against an in-bench predictor.
// Depends on stpm_pkg and the RTL under src.
module shared_timer_period_meter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stpm_pkg::*;

   localparam int unsigned NUM_CH     = 2;
   localparam int unsigned SETTLE_CYC = 48;
   localparam logic [15:0] TALLY_SAT  = 16'hFFFF;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              channel;
   } freq_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_func;
   logic              req_channel;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [DATA_W-1:0] rsp_freq_value;
   logic              rsp_freq_channel;
   logic              csr_write_en;
   logic              csr_index;
   logic [DATA_W-1:0] csr_wdata;

   // predicted meter state and registers
   logic [DATA_W-1:0] osc_reg;
   logic [DATA_W-1:0] timeout_reg;
   int unsigned       timer_owner;
   logic [DATA_W-1:0] tick_count;
   logic [DATA_W-1:0] period_mem [NUM_CH];
   logic [15:0]       tally_mem [NUM_CH];

   freq_result_type pending_freq_q[$];
   int unsigned  mismatch_count;
   int unsigned  reads_checked;
   int unsigned  periods_captured;
   int unsigned  timeouts_seen;
   int unsigned  silent_marks;
   int unsigned  active_items;
   bit           quiet;

   shared_timer_period_meter_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_channel      (req_channel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_freq_value   (rsp_freq_value),
      .rsp_freq_channel (rsp_freq_channel),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // predictor: advances the meter state for one accepted item
   function automatic void meter_predict(logic [1:0] func, logic ch);
      freq_result_type res;
      case (func)
         FUNC_TICK: begin
            if (timer_owner != 0) begin
               active_items++;
               if (tick_count != ALL_ONES) tick_count++;
               if (tick_count > timeout_reg) begin
                  period_mem[timer_owner-1] = ALL_ONES;
                  timer_owner = 0;
                  tick_count = '0;
                  timeouts_seen++;
               end
            end
         end
         FUNC_EDGE: begin
            active_items++;
            if (tally_mem[ch] != TALLY_SAT) tally_mem[ch]++;
            if (timer_owner == int'(ch) + 1) begin
               period_mem[ch] = tick_count;
               timer_owner = 0;
               periods_captured++;
            end else if (timer_owner == 0) begin
               tick_count = '0;
               timer_owner = int'(ch) + 1;
            end
         end
         FUNC_SECOND: begin
            active_items++;
            for (int i = 0; i < NUM_CH; i++) begin
               if (tally_mem[i] == '0) begin
                  period_mem[i] = ALL_ONES;
                  silent_marks++;
               end
               tally_mem[i] = '0;
            end
         end
         default: begin
            active_items++;
            res.channel = ch;
            res.value = (period_mem[ch] == '0) ? ALL_ONES : osc_reg / period_mem[ch];
            pending_freq_q.push_back(res);
         end
      endcase
   endfunction

   // send one item, holding valid and payload until accepted
   task automatic send_item(logic [1:0] func, logic ch);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_channel <= ch;
      do @(posedge clock); while (!req_ready);
      meter_predict(func, ch);
   endtask

   // drop valid, wait for every expected result, then let the block finish
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_freq_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // register write, only called while the block is idle
   task automatic write_register(logic idx, logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_OSC_FREQ) osc_reg = data;
      else timeout_reg = data;
   endtask

   // result checker
   always @(posedge clock) begin
      freq_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_freq_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result value %h channel %0d", $time,
                     rsp_freq_value, rsp_freq_channel);
         end else begin
            exp_res = pending_freq_q.pop_front();
            reads_checked++;
            if (rsp_freq_value !== exp_res.value) begin
               mismatch_count++;
               $display("%0t: freq_value expected %h actual %h", $time,
                        exp_res.value, rsp_freq_value);
            end
            if (rsp_freq_channel !== exp_res.channel) begin
               mismatch_count++;
               $display("%0t: freq_channel expected %0d actual %0d", $time,
                        exp_res.channel, rsp_freq_channel);
            end
         end
      end
   end

   // result-side stalls
   always @(negedge clock) begin
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
   end

   // reads at reset, a normal capture, other-channel edge, zero period, silent channels
   task automatic test_period_capture();
      send_item(FUNC_READ, 1'b0);
      send_item(FUNC_READ, 1'b1);
      send_item(FUNC_EDGE, 1'b0);
      repeat (3) send_item(FUNC_TICK, 1'b0);
      send_item(FUNC_EDGE, 1'b1);
      send_item(FUNC_EDGE, 1'b0);
      send_item(FUNC_READ, 1'b0);
      // tick while free does not count
      send_item(FUNC_TICK, 1'b1);
      send_item(FUNC_EDGE, 1'b1);
      send_item(FUNC_EDGE, 1'b1);
      send_item(FUNC_READ, 1'b1);
      send_item(FUNC_SECOND, 1'b0);
      send_item(FUNC_READ, 1'b0);
      send_item(FUNC_SECOND, 1'b1);
      send_item(FUNC_READ, 1'b0);
      send_item(FUNC_READ, 1'b1);
      settle();
   endtask

   // timeout at a limit of one tick, then zero and full-scale oscillator words
   task automatic test_timeout_and_osc();
      write_register(CSR_TIMEOUT, 32'd1);
      send_item(FUNC_EDGE, 1'b0);
      send_item(FUNC_TICK, 1'b0);
      send_item(FUNC_TICK, 1'b0);
      send_item(FUNC_READ, 1'b0);
      send_item(FUNC_EDGE, 1'b1);
      send_item(FUNC_TICK, 1'b0);
      send_item(FUNC_EDGE, 1'b1);
      send_item(FUNC_READ, 1'b1);
      settle();
      write_register(CSR_OSC_FREQ, '0);
      send_item(FUNC_READ, 1'b1);
      send_item(FUNC_READ, 1'b0);
      settle();
      write_register(CSR_OSC_FREQ, ALL_ONES);
      send_item(FUNC_READ, 1'b1);
      settle();
   endtask

   // random traffic, mostly complete measurements with noise mixed in
   task automatic test_random_traffic(logic [DATA_W-1:0] osc, logic [DATA_W-1:0] tmo,
                                      int unsigned tick_span, int unsigned target);
      int unsigned start;
      int unsigned pick;
      int unsigned n_ticks;
      logic        ch;
      write_register(CSR_OSC_FREQ, osc);
      write_register(CSR_TIMEOUT, tmo);
      start = active_items;
      while (active_items - start < target) begin
         pick = $urandom_range(99);
         ch = 1'($urandom_range(1));
         if (pick < 60) begin
            send_item(FUNC_EDGE, ch);
            n_ticks = $urandom_range(tick_span);
            for (int i = 0; i < n_ticks; i++) begin
               pick = $urandom_range(99);
               if (pick < 6) send_item(FUNC_EDGE, ~ch);
               else if (pick < 10) send_item(FUNC_READ, 1'($urandom_range(1)));
               else send_item(FUNC_TICK, 1'($urandom_range(1)));
            end
            send_item(FUNC_EDGE, ch);
            if ($urandom_range(1)) send_item(FUNC_READ, ch);
         end else if (pick < 75) begin
            send_item(FUNC_READ, ch);
         end else if (pick < 81) begin
            send_item(FUNC_SECOND, ch);
         end else if (pick < 92) begin
            send_item(FUNC_TICK, ch);
         end else begin
            send_item(FUNC_EDGE, ch);
         end
         // a stretch without any idling in the second half of the last phase
         if (tmo == ALL_ONES) quiet = (active_items - start > target / 2);
      end
      settle();
      quiet = 1'b0;
   endtask

   // sequence of tests
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = FUNC_TICK;
      req_channel  = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = CSR_OSC_FREQ;
      csr_wdata    = '0;
      quiet        = 1'b0;
      osc_reg      = OSC_FREQ_RESET;
      timeout_reg  = TIMEOUT_RESET;
      timer_owner  = 0;
      tick_count   = '0;
      for (int i = 0; i < NUM_CH; i++) begin
         period_mem[i] = '0;
         tally_mem[i]  = '0;
      end
      mismatch_count   = 0;
      reads_checked    = 0;
      periods_captured = 0;
      timeouts_seen    = 0;
      silent_marks     = 0;
      active_items     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYC) @(posedge clock);

      test_period_capture();
      test_timeout_and_osc();
      test_random_traffic(OSC_FREQ_RESET, TIMEOUT_RESET, 40, 400);
      test_random_traffic($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(30, 4), 40, 400);
      test_random_traffic(ALL_ONES, 32'd1, 3, 300);
      test_random_traffic($urandom_range(1000, 1), ALL_ONES, 60, 400);

      $display("Checked %0d reads over %0d captured periods, %0d timeouts,",
               reads_checked, periods_captured, timeouts_seen);
      $display("%0d silent-channel marks, zero and full-scale oscillator words",
               silent_marks);
      if (mismatch_count == 0 && pending_freq_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/stpm_pkg.sv
src/stpm_div.sv
src/shared_timer_period_meter_unit.sv
src/stpm_checker.sv
dv/shared_timer_period_meter_unit_tb.sv
